@@ rtl/sspwm_pkg.sv @@
// Shared types and constants for the serial-set multi-channel PWM block.
// Used by the register file, the PWM core and the top level.
package sspwm_pkg;

   localparam int CHANNELS_DEF = 8;
   localparam int CHANNELS_MAX = 8;

   localparam int PIN_W    = 8;
   localparam int BYTE_W   = 8;
   localparam int DUTY_W   = 10;
   localparam int PHASE_W  = 16;
   localparam int ENABLE_W = 8;
   localparam int IDX_W    = 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic REG_ENABLE_MASK = 1'b0;
   localparam logic REG_PHASE_MASK  = 1'b1;

   localparam logic [ENABLE_W-1:0] ENABLE_MASK_RST = '0;
   localparam logic [PHASE_W-1:0]  PHASE_MASK_RST  = 16'h00FF;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_BYTE = 1'b1;

   localparam int HEADER_BIT = 7;

   typedef struct packed {
      logic [ENABLE_W-1:0] enable_mask;
      logic [PHASE_W-1:0]  phase_mask;
   } cfg_type;

endpackage

@@ rtl/serial_set_multi_channel_pwm.sv @@
// Serial-set multi-channel PWM generator, top level.
// A tick beat's pin levels are registered in the result register, or in the
// skid entry behind it when the result is stalled. Throughput: one beat per
// cycle unless the skid entry is full; phase and duty compares feed the result.
// Reset (synchronous, active high): duties zero, no header, phase = 255,
// enable_mask = 0, phase_mask = 255, no result pending.
module serial_set_multi_channel_pwm
   import sspwm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIN_W-1:0]      rsp_pin_levels,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   sspwm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sspwm_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pin_levels (rsp_pin_levels)
   );

endmodule

@@ rtl/sspwm_csr.sv @@
// APB-style configuration registers: enable mask and phase wrap mask.
// Depends on sspwm_pkg.
module sspwm_csr
   import sspwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_ENABLE_MASK: cfg_in.enable_mask = pwdata[ENABLE_W-1:0];
            REG_PHASE_MASK:  cfg_in.phase_mask  = pwdata[PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_mask <= ENABLE_MASK_RST;
         cfg_ff.phase_mask  <= PHASE_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ENABLE_MASK: prdata = {{(CSR_DATA_W-ENABLE_W){1'b0}}, cfg_ff.enable_mask};
         REG_PHASE_MASK:  prdata = {{(CSR_DATA_W-PHASE_W){1'b0}}, cfg_ff.phase_mask};
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/sspwm_core.sv @@
// PWM core: header/data byte decoder, duty registers, phase counter,
// per-channel comparators and the result register with a skid stage.
// Depends on sspwm_pkg.
module sspwm_core
   import sspwm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PIN_W-1:0]  rsp_pin_levels
);

   logic              accept, tick, rx;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [DUTY_W-1:0] duty_ff [CHANNELS];
   logic [DUTY_W-1:0] duty_val;
   logic [IDX_W-1:0]  wr_idx;
   logic              wr_en;
   logic [PHASE_W-1:0] phase_ff, phase_next;
   logic [PIN_W-1:0]  levels;

   logic              out_valid_ff, out_valid_in;
   logic [PIN_W-1:0]  out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [PIN_W-1:0]  skid_ff, skid_in;
   logic              out_take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign tick      = accept & (req_command == CMD_TICK);
   assign rx        = accept & (req_command == CMD_BYTE);

   // byte decoder: header byte, then a data byte completes the duty write
   always_comb begin
      header_in = header_ff;
      wr_en     = 1'b0;
      if (rx) begin
         if (header_ff != '0) begin
            wr_en     = ~req_rx_byte[HEADER_BIT];
            header_in = '0;
         end else if (req_rx_byte[HEADER_BIT]) begin
            header_in = req_rx_byte;
         end
      end
   end

   assign wr_idx = header_ff[5:3];

   always_comb begin
      duty_val = {header_ff[2:0], req_rx_byte[6:0]};
      // narrow mode keeps 8-bit duty values
      if (cfg.phase_mask[PHASE_W-1:8] == '0) begin
         duty_val[DUTY_W-1:8] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         phase_ff  <= PHASE_MASK_RST;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            duty_ff[ch] <= '0;
         end
      end else begin
         header_ff <= header_in;
         if (tick) begin
            phase_ff <= phase_next;
         end
         for (int ch = 0; ch < CHANNELS; ch++) begin
            if (wr_en && wr_idx == IDX_W'(ch)) begin
               duty_ff[ch] <= duty_val;
            end
         end
      end
   end

   assign phase_next = (phase_ff + PHASE_W'(1)) & cfg.phase_mask;

   always_comb begin
      levels = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         levels[ch] = ({{(PHASE_W-DUTY_W){1'b0}}, duty_ff[ch]} >= phase_next);
      end
      levels = levels & cfg.enable_mask;
   end

   // result register plus one skid entry
   assign out_take = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (tick) begin
         if (!out_valid_ff || out_take) begin
            out_in       = levels;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = levels;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pin_levels = out_ff;

endmodule

@@ rtl/sspwm_checker.sv @@
// Port-level checks for the PWM top level, attached by bind.
// Depends on sspwm_pkg for field widths.
module sspwm_checker
   import sspwm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_command,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [PIN_W-1:0]  rsp_pin_levels
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pin_levels))
      else $error("stalled result beat changed");

   // input stalls only while the result register is full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");

   // every tick beat produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_TICK |=> rsp_valid)
      else $error("tick beat gave no result");

   // a serial byte never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_BYTE && !rsp_valid |=> !rsp_valid)
      else $error("serial byte produced a result");

endmodule

bind serial_set_multi_channel_pwm sspwm_checker u_sspwm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pin_levels (rsp_pin_levels)
);

@@ verif/serial_set_multi_channel_pwm_tb.sv @@
// Testbench for serial_set_multi_channel_pwm: drives ticks and serial bytes,
// programs the enable and phase masks over APB, and scores every pin result.
// Depends on sspwm_pkg and the serial_set_multi_channel_pwm top level.
module serial_set_multi_channel_pwm_tb;
   import sspwm_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 4;

   class pwm_scoreboard;
      bit [ENABLE_W-1:0] enable_mask;
      bit [PHASE_W-1:0]  phase_mask;
      bit [BYTE_W-1:0]   header;
      bit [DUTY_W-1:0]   duty[CHANNELS_DEF];
      bit [PHASE_W-1:0]  phase;
      bit [PIN_W-1:0]    levels_q[$];
      int                errors;
      int                checked;
      int                beats;

      function new();
         enable_mask = ENABLE_MASK_RST;
         phase_mask  = PHASE_MASK_RST;
         header      = '0;
         foreach (duty[i]) duty[i] = '0;
         phase       = PHASE_MASK_RST;
      endfunction

      function void set_reg(logic idx, bit [CSR_DATA_W-1:0] value);
         if (idx == REG_ENABLE_MASK) enable_mask = value[ENABLE_W-1:0];
         else phase_mask = value[PHASE_W-1:0];
      endfunction

      function bit [CSR_DATA_W-1:0] reg_value(logic idx);
         if (idx == REG_ENABLE_MASK) return CSR_DATA_W'(enable_mask);
         return CSR_DATA_W'(phase_mask);
      endfunction

      // accepted input beat: a tick queues one pin result, a byte only
      // updates the header / duty state
      function void note_beat(logic cmd, bit [BYTE_W-1:0] b);
         bit [PIN_W-1:0]  lv;
         bit [DUTY_W-1:0] val;
         int              idx;
         beats++;
         if (cmd == CMD_TICK) begin
            phase = (phase + 16'd1) & phase_mask;
            lv = '0;
            for (int ch = 0; ch < CHANNELS_DEF; ch++)
               if (duty[ch] >= phase) lv[ch] = 1'b1;
            levels_q.push_back(lv & enable_mask);
         end else if (header != '0) begin
            if (!b[HEADER_BIT]) begin
               idx = int'(header[5:3]);
               val = {header[2:0], b[6:0]};
               if (phase_mask <= 16'h00FF) val = val & 10'h0FF;
               if (idx < CHANNELS_DEF) duty[idx] = val;
            end
            header = '0;
         end else if (b[HEADER_BIT]) begin
            header = b;
         end
      endfunction

      function void check_levels(bit [PIN_W-1:0] act);
         bit [PIN_W-1:0] exp_lv;
         if (levels_q.size() == 0) begin
            $display("%0t: pin_levels expected none, got %02h", $time, act);
            errors++;
            return;
         end
         exp_lv = levels_q.pop_front();
         checked++;
         if (exp_lv !== act) begin
            $display("%0t: pin_levels expected %02h, got %02h", $time, exp_lv, act);
            errors++;
         end
      endfunction

      function int pending();
         return levels_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_TICK;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIN_W-1:0]      rsp_pin_levels;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pwm_scoreboard sb = new();
   int            gap_pct;
   int            stall_pct;
   int            cycles;
   int            reg_writes;

   serial_set_multi_channel_pwm u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pin_levels (rsp_pin_levels),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d pin results still expected", $time, sb.pending());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // input beat is noted before the result so a same-edge result still
   // finds its expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_beat(req_command, req_rx_byte);
         if (rsp_valid && !rsp_stall) sb.check_levels(rsp_pin_levels);
      end
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // entered and left at a falling edge; valid stays up after the beat
   task automatic send_beat(logic cmd, logic [BYTE_W-1:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_beat(CMD_TICK, BYTE_W'($urandom_range(255)));
   endtask

   task automatic send_byte(logic [BYTE_W-1:0] b);
      send_beat(CMD_BYTE, b);
   endtask

   // wait until every pin result is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // APB write followed by a readback of the same register
   task automatic csr_write(logic idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] exp_rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
      reg_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      exp_rd = sb.reg_value(idx);
      if (prdata !== exp_rd) begin
         $display("%0t: register %0d readback expected %08h, got %08h",
                  $time, idx, exp_rd, prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_burst(int n_items, bit pause_midway);
      int sent;
      int r;
      sent = 0;
      while (sent < n_items) begin
         if (pause_midway && sent >= n_items / 2) begin
            drain();
            pause_midway = 1'b0;
         end
         r = $urandom_range(99);
         if (r < 45) begin
            send_tick();
            sent++;
         end else if (r < 85) begin
            // well-formed duty write
            send_byte({1'b1, 7'($urandom_range(127))});
            send_byte({1'b0, 7'($urandom_range(127))});
            sent += 2;
         end else if (r < 93) begin
            send_byte(BYTE_W'($urandom_range(255)));
            sent++;
         end else begin
            // header followed by header
            send_byte({1'b1, 7'($urandom_range(127))});
            send_byte({1'b1, 7'($urandom_range(127))});
            sent += 2;
         end
      end
   endtask

   initial begin
      logic [PHASE_W-1:0]  masks[10];
      logic [ENABLE_W-1:0] enables[10];
      masks   = '{16'd15, 16'd1023, 16'd3, 16'd256, 16'd255,
                  16'd0, 16'd511, 16'd63, 16'hFFFF, 16'd127};
      enables = '{8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h5A, 8'hFF, 8'h0F, 8'hFF, 8'hF0, 8'hFF};
      gap_pct   = 0;
      stall_pct = 0;
      cycles    = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, enable mask still zero
      send_tick();
      drain();
      csr_write(REG_ENABLE_MASK, 32'hFFFF_FFFF);
      send_byte(8'h55);               // data byte with no header pending
      send_tick();
      send_byte(8'hBF);               // channel 7, narrow mode keeps low 8 bits
      send_byte(8'h7F);
      send_tick();
      send_byte(8'h81);               // header then header: both dropped
      send_byte(8'h88);
      send_byte(8'h12);
      send_tick();
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'h9A);
      send_byte(8'h45);
      send_tick();
      send_tick();
      drain();
      csr_write(REG_PHASE_MASK, 32'h0000_03FF);
      send_byte(8'hBF);               // wide mode, full 10-bit duty
      send_byte(8'h7F);
      send_tick();
      drain();
      csr_write(REG_PHASE_MASK, 32'h0000_0000);
      send_tick();
      send_tick();
      drain();
      csr_write(REG_PHASE_MASK, 32'hFFFF_FFFF);
      send_tick();
      drain();

      for (int seg = 0; seg < 10; seg++) begin
         case (seg % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 53; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 12; stall_pct = 12; end
         endcase
         csr_write(REG_ENABLE_MASK, ($urandom & 32'hFFFF_FF00) | enables[seg]);
         csr_write(REG_PHASE_MASK, ($urandom & 32'hFFFF_0000) | masks[seg]);
         random_burst(112, seg == 5);
         drain();
      end

      $display("%0d beats driven, %0d pin results checked, %0d register writes",
               sb.beats, sb.checked, reg_writes);
      $display("phase masks from 0 to 65535 with narrow and wide duty writes");
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sspwm_pkg.sv
rtl/sspwm_csr.sv
rtl/sspwm_core.sv
rtl/serial_set_multi_channel_pwm.sv
rtl/sspwm_checker.sv
verif/serial_set_multi_channel_pwm_tb.sv
